// File: rtl/ucdp_pkg.sv
// Types and constants shared by the AudioControl descriptor parser modules.
`timescale 1ns / 1ps

package ucdp_pkg;

  localparam logic [7:0]  CsInterfaceType  = 8'h24;
  localparam logic [7:0]  SubHeader        = 8'h01;
  localparam logic [7:0]  SubFeatureUnit   = 8'h06;
  localparam logic [7:0]  SubClockSource   = 8'h0A;
  localparam logic [7:0]  SubClockSelector = 8'h0B;
  localparam logic [15:0] Uac2Version      = 16'h0200;

  localparam int unsigned CaptureDepth = 6;
  localparam int unsigned ResultWidth  = 48;

  // Master volume codes of a UAC2 feature unit.
  localparam logic [1:0] VolCodeNone = 2'd0;
  localparam logic [1:0] VolCodeHost = 2'd3;

  // Volume kinds reported in the summary.
  localparam logic [1:0] VolKindHost    = 2'd1;
  localparam logic [1:0] VolKindReadOnly = 2'd2;
  localparam logic [1:0] VolKindUac1    = 2'd3;

  // A completed descriptor: its length and bytes 1 to 6 after bLength.
  typedef struct packed {
    logic [7:0]                   len;
    logic [CaptureDepth-1:0][7:0] bytes;
  } desc_t;

  // Updates to the summary state caused by one completed descriptor.
  typedef struct packed {
    logic        version_we;
    logic [15:0] version;
    logic        source_we;
    logic [7:0]  source_id;
    logic        source_prog;
    logic        selector_we;
    logic [7:0]  selector_id;
    logic        feature_we;
    logic [7:0]  feature_id;
    logic        volume_we;
    logic        volume_host;
    logic [1:0]  volume_kind;
  } upd_t;

endpackage

// File: rtl/ucdp_desc_eval.sv
// Evaluation of one completed class-specific AudioControl descriptor.
`timescale 1ns / 1ps

module ucdp_desc_eval (
  input  ucdp_pkg::desc_t     desc_i,
  input  logic [15:0]         version_i,
  output ucdp_pkg::upd_t      upd_o
);
  import ucdp_pkg::*;

  logic       cs_iface;
  logic [1:0] vol_code;

  always_comb begin
    upd_o    = '0;
    cs_iface = (desc_i.len >= 8'd3) && (desc_i.bytes[0] == CsInterfaceType);
    vol_code = desc_i.bytes[4][3:2];

    upd_o.version     = {desc_i.bytes[3], desc_i.bytes[2]};
    upd_o.source_id   = desc_i.bytes[2];
    upd_o.source_prog = (desc_i.bytes[4][1:0] == 2'b11);
    upd_o.selector_id = desc_i.bytes[2];
    upd_o.feature_id  = desc_i.bytes[2];

    upd_o.version_we  = cs_iface && (desc_i.bytes[1] == SubHeader) && (desc_i.len >= 8'd5);
    upd_o.source_we   = cs_iface && (desc_i.bytes[1] == SubClockSource)
                        && (desc_i.len >= 8'd6);
    upd_o.selector_we = cs_iface && (desc_i.bytes[1] == SubClockSelector)
                        && (desc_i.len >= 8'd4);
    upd_o.feature_we  = cs_iface && (desc_i.bytes[1] == SubFeatureUnit)
                        && (desc_i.len >= 8'd6);

    // Volume rule depends on the audio class version seen so far.
    if (upd_o.feature_we) begin
      if (version_i >= Uac2Version) begin
        if (desc_i.len >= 8'd9 && vol_code != VolCodeNone) begin
          upd_o.volume_we = 1'b1;
          if (vol_code == VolCodeHost) begin
            upd_o.volume_host = 1'b1;
            upd_o.volume_kind = VolKindHost;
          end else begin
            upd_o.volume_host = 1'b0;
            upd_o.volume_kind = VolKindReadOnly;
          end
        end
      end else if (desc_i.bytes[4] != 8'd0 && desc_i.len >= 8'd7 && desc_i.bytes[5][1]) begin
        upd_o.volume_we   = 1'b1;
        upd_o.volume_host = 1'b1;
        upd_o.volume_kind = VolKindUac1;
      end
    end
  end

endmodule

// File: rtl/uac_control_descriptor_parser_core.sv
// Top level of the USB audio class AudioControl descriptor parser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Transfer contents
//  s_axis    in         one descriptor byte; tlast marks the final byte of the block
//  m_axis    out        one 48-bit summary, sent for the transfer that carried tlast
//
// The walker state and the summary state update in the cycle the byte transfer is
// taken, and a block summary lands in the output register in that same cycle, so
// bytes can arrive back to back without gaps unless a waiting summary stalls s_axis.
// Reset clears the walker, the summary state and the output valid flag.
// While a summary waits in the output register and the sink holds m_axis_tready low,
// s_axis_tready is low; a summary taken in a cycle frees the way for a new byte
// in that same cycle.

module uac_control_descriptor_parser_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: data_byte [7:0]
  input  logic [7:0]                         s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: uac_version [15:0], clock_source_id [23:16], clock_source_found [24],
  //        clock_programmable [25], clock_selector_id [33:26], clock_selector_found [34],
  //        feature_unit_id [42:35], feature_unit_found [43], volume_host_control [44],
  //        volume_kind [46:45], walk_stopped [47]
  output logic [ucdp_pkg::ResultWidth-1:0]   m_axis_tdata_o
);
  import ucdp_pkg::*;

  // Walker state: position inside the current descriptor and its bLength.
  logic [7:0]                   pos_q, pos_d;
  logic [7:0]                   len_q, len_d;
  logic                         stopped_q, stopped_d;
  // Bytes 1 to 6 of the descriptor in progress; later bytes are never used.
  logic [CaptureDepth-1:0][7:0] capt_q, capt_d;

  // Summary state.
  logic [15:0] version_q, version_d;
  logic [7:0]  src_id_q, src_id_d;
  logic        src_found_q, src_found_d;
  logic        src_prog_q, src_prog_d;
  logic [7:0]  sel_id_q, sel_id_d;
  logic        sel_found_q, sel_found_d;
  logic [7:0]  fu_id_q, fu_id_d;
  logic        fu_found_q, fu_found_d;
  logic        vol_host_q, vol_host_d;
  logic [1:0]  vol_kind_q, vol_kind_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [ResultWidth-1:0] out_data_q, out_data_d;

  logic   accept;
  logic   complete;
  logic   final_stopped;
  desc_t  desc;
  upd_t   upd;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The descriptor as seen with the current byte merged into the capture.
  always_comb begin
    capt_d = capt_q;
    if (accept && !stopped_q && pos_q != 8'd0 && pos_q <= 8'(CaptureDepth)) begin
      capt_d[pos_q[2:0] - 3'd1] = s_axis_tdata_i;
    end
    desc.len   = len_q;
    desc.bytes = capt_d;
  end

  ucdp_desc_eval u_desc_eval (
    .desc_i    (desc),
    .version_i (version_q),
    .upd_o     (upd)
  );

  // A descriptor ends on the byte whose position plus one reaches bLength.
  assign complete = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    stopped_d   = stopped_q;
    version_d   = version_q;
    src_id_d    = src_id_q;
    src_found_d = src_found_q;
    src_prog_d  = src_prog_q;
    sel_id_d    = sel_id_q;
    sel_found_d = sel_found_q;
    fu_id_d     = fu_id_q;
    fu_found_d  = fu_found_q;
    vol_host_d  = vol_host_q;
    vol_kind_d  = vol_kind_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    final_stopped = 1'b0;

    if (accept) begin
      if (!stopped_q) begin
        if (pos_q == 8'd0) begin
          // First byte of a descriptor is its length; under two ends the walk.
          len_d = s_axis_tdata_i;
          if (s_axis_tdata_i < 8'd2) begin
            stopped_d = 1'b1;
          end else begin
            pos_d = 8'd1;
          end
        end else if (complete) begin
          pos_d = 8'd0;
          if (upd.version_we) begin
            version_d = upd.version;
          end
          if (upd.source_we) begin
            src_id_d    = upd.source_id;
            src_found_d = 1'b1;
            src_prog_d  = upd.source_prog;
          end
          if (upd.selector_we) begin
            sel_id_d    = upd.selector_id;
            sel_found_d = 1'b1;
          end
          if (upd.feature_we) begin
            fu_id_d    = upd.feature_id;
            fu_found_d = 1'b1;
          end
          if (upd.volume_we) begin
            vol_host_d = upd.volume_host;
            vol_kind_d = upd.volume_kind;
          end
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end

      if (s_axis_tlast_i) begin
        // A block that ends inside a descriptor counts as a stopped walk.
        final_stopped = stopped_d || (pos_d != 8'd0);
        out_valid_d   = 1'b1;
        out_data_d    = {final_stopped, vol_kind_d, vol_host_d, fu_found_d, fu_id_d,
                         sel_found_d, sel_id_d, src_prog_d, src_found_d, src_id_d,
                         version_d};
        pos_d       = '0;
        len_d       = '0;
        stopped_d   = 1'b0;
        version_d   = '0;
        src_id_d    = '0;
        src_found_d = 1'b0;
        src_prog_d  = 1'b0;
        sel_id_d    = '0;
        sel_found_d = 1'b0;
        fu_id_d     = '0;
        fu_found_d  = 1'b0;
        vol_host_d  = 1'b0;
        vol_kind_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      stopped_q   <= 1'b0;
      version_q   <= '0;
      src_id_q    <= '0;
      src_found_q <= 1'b0;
      src_prog_q  <= 1'b0;
      sel_id_q    <= '0;
      sel_found_q <= 1'b0;
      fu_id_q     <= '0;
      fu_found_q  <= 1'b0;
      vol_host_q  <= 1'b0;
      vol_kind_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      len_q       <= len_d;
      stopped_q   <= stopped_d;
      version_q   <= version_d;
      src_id_q    <= src_id_d;
      src_found_q <= src_found_d;
      src_prog_q  <= src_prog_d;
      sel_id_q    <= sel_id_d;
      sel_found_q <= sel_found_d;
      fu_id_q     <= fu_id_d;
      fu_found_q  <= fu_found_d;
      vol_host_q  <= vol_host_d;
      vol_kind_q  <= vol_kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    capt_q     <= capt_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the AudioControl descriptor parser core.
`timescale 1ns / 1ps

module testbench;
  import ucdp_pkg::*;

  // Block summary as it travels on m_axis_tdata_o, highest field first.
  typedef struct packed {
    logic        walk_stopped;
    logic [1:0]  volume_kind;
    logic        volume_host_control;
    logic        feature_unit_found;
    logic [7:0]  feature_unit_id;
    logic        clock_selector_found;
    logic [7:0]  clock_selector_id;
    logic        clock_programmable;
    logic        clock_source_found;
    logic [7:0]  clock_source_id;
    logic [15:0] uac_version;
  } summary_t;

  // One byte transfer; directed rows may carry a hand-written summary.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    summary_t   want;
  } transfer_t;

  typedef enum int {
    DescHeader, DescSource, DescSelector, DescFeature, DescOtherSub, DescOtherType, DescBare
  } desc_kind_e;

  typedef enum int {EndClean, EndCutShort, EndBadLength, EndNoise} block_end_e;

  localparam int RandomItems = 1250;
  localparam int IdleLimit   = 500;
  localparam int DirCount    = 27;

  // Directed rows as {last, data}.
  localparam logic [8:0] DirBytes [DirCount] = '{
    // UAC2 header, feature unit with host volume, programmable clock source.
    9'h005, 9'h024, 9'h001, 9'h000, 9'h002,
    9'h009, 9'h024, 9'h006, 9'h0FF, 9'h001, 9'h00C, 9'h000, 9'h000, 9'h000,
    9'h006, 9'h024, 9'h00A, 9'h080, 9'h000, 9'h103,
    // Clock selector, then the block ends on a lone length byte.
    9'h004, 9'h024, 9'h00B, 9'h0FF, 9'h107,
    // Zero length stops the walk; the final byte is ignored.
    9'h000, 9'h1FF
  };

  localparam summary_t DirSummaries [3] = '{
    '{uac_version: 16'h0200, clock_source_id: 8'h80, clock_source_found: 1'b1,
      clock_programmable: 1'b1, feature_unit_id: 8'hFF, feature_unit_found: 1'b1,
      volume_host_control: 1'b1, volume_kind: VolKindHost, default: '0},
    '{clock_selector_id: 8'hFF, clock_selector_found: 1'b1, walk_stopped: 1'b1, default: '0},
    '{walk_stopped: 1'b1, default: '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [ResultWidth-1:0] m_axis_tdata_o;

  always #6 clk_i = ~clk_i;

  uac_control_descriptor_parser_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  transfer_t  byte_stream [$];
  summary_t   pending_summaries [$];
  int         mismatches = 0;
  int         idle_cycles = 0;

  // Walker state of the parser model.
  logic [7:0] walk_pos = '0;
  logic [7:0] walk_len = '0;
  logic [7:0] desc_bytes [1:8] = '{default: '0};
  summary_t   block_summary = '0;

  // Advances the parser model by one byte; on the final byte hands out the summary.
  task automatic walk_descriptor_byte(input logic [7:0] b, input logic fin,
                                      output logic emitted, output summary_t res);
    logic [1:0] vol_code;
    emitted = 1'b0;
    res = '0;
    if (!block_summary.walk_stopped) begin
      if (walk_pos == 0) begin
        walk_len = b;
        if (b < 2) block_summary.walk_stopped = 1'b1;
        else walk_pos = 8'd1;
      end else begin
        if (walk_pos <= 8) desc_bytes[walk_pos] = b;
        if (int'(walk_pos) + 1 >= int'(walk_len)) begin
          // Descriptor complete: only CS_INTERFACE descriptors of length 3 or more count.
          if (walk_len >= 3 && desc_bytes[1] == CsInterfaceType) begin
            case (desc_bytes[2])
              SubHeader: begin
                if (walk_len >= 5) block_summary.uac_version = {desc_bytes[4], desc_bytes[3]};
              end
              SubClockSource: begin
                if (walk_len >= 6) begin
                  block_summary.clock_source_id    = desc_bytes[3];
                  block_summary.clock_source_found = 1'b1;
                  block_summary.clock_programmable = &desc_bytes[5][1:0];
                end
              end
              SubClockSelector: begin
                if (walk_len >= 4) begin
                  block_summary.clock_selector_id    = desc_bytes[3];
                  block_summary.clock_selector_found = 1'b1;
                end
              end
              SubFeatureUnit: begin
                if (walk_len >= 6) begin
                  block_summary.feature_unit_id    = desc_bytes[3];
                  block_summary.feature_unit_found = 1'b1;
                  if (block_summary.uac_version >= Uac2Version) begin
                    if (walk_len >= 9) begin
                      vol_code = desc_bytes[5][3:2];
                      if (vol_code == VolCodeHost)
                        {block_summary.volume_host_control, block_summary.volume_kind} =
                          {1'b1, VolKindHost};
                      else if (vol_code != VolCodeNone)
                        {block_summary.volume_host_control, block_summary.volume_kind} =
                          {1'b0, VolKindReadOnly};
                    end
                  end else if (desc_bytes[5] >= 1 && walk_len >= 7 && desc_bytes[6][1]) begin
                    {block_summary.volume_host_control, block_summary.volume_kind} =
                      {1'b1, VolKindUac1};
                  end
                end
              end
              default: ;
            endcase
          end
          walk_pos = '0;
        end else begin
          walk_pos++;
        end
      end
    end
    if (fin) begin
      // A block that ends inside a descriptor counts as a stopped walk.
      if (walk_pos != 0) block_summary.walk_stopped = 1'b1;
      emitted = 1'b1;
      res = block_summary;
      walk_pos = '0;
      walk_len = '0;
      foreach (desc_bytes[k]) desc_bytes[k] = '0;
      block_summary = '0;
    end
  endtask

  // Appends one random descriptor block, mostly well formed, to the byte stream.
  task automatic build_block();
    logic [7:0] blk [$];
    transfer_t  t;
    desc_kind_e kind;
    block_end_e ending;
    logic [7:0] dtype, sub;
    logic [15:0] ver;
    int r, ndesc, need, len, d, k;
    r = $urandom_range(0, 9);
    ending = (r <= 5) ? EndClean : (r == 6) ? EndCutShort : (r <= 8) ? EndBadLength : EndNoise;
    ndesc = (ending == EndNoise) ? 0 :
            (ending == EndBadLength) ? $urandom_range(0, 5) : $urandom_range(1, 6);
    for (d = 0; d < ndesc; d++) begin
      kind = desc_kind_e'($urandom_range(0, 6));
      dtype = CsInterfaceType;
      case (kind)
        DescHeader:    begin sub = SubHeader;        need = 5; end
        DescSource:    begin sub = SubClockSource;   need = 6; end
        DescSelector:  begin sub = SubClockSelector; need = 4; end
        DescFeature:   begin sub = SubFeatureUnit;   need = 6; end
        DescOtherType: begin sub = 8'($urandom_range(0, 255)); dtype = 8'($urandom_range(0, 255));
                             need = 2; end
        default:       begin sub = 8'($urandom_range(0, 255)); need = 2; end
      endcase
      case ($urandom_range(0, 5))
        0: ver = 16'h0100;
        1: ver = Uac2Version;
        2: ver = 16'h01FF;
        3: ver = 16'hFFFF;
        default: ver = 16'($urandom_range(0, 65535));
      endcase
      if (kind == DescBare) len = 2;
      else if ($urandom_range(0, 39) == 0) len = $urandom_range(2, 255);
      else if (need > 2 && $urandom_range(0, 3) == 0) len = $urandom_range(2, need - 1);
      else len = (need > 2) ? $urandom_range(need, need + 8) : $urandom_range(2, 12);
      blk = {blk, len[7:0]};
      for (k = 1; k < len; k++) begin
        case (k)
          1: blk = {blk, dtype};
          2: blk = {blk, sub};
          3: blk = {blk, (kind == DescHeader) ? ver[7:0] : 8'($urandom_range(0, 255))};
          4: blk = {blk, (kind == DescHeader) ? ver[15:8] : 8'($urandom_range(0, 255))};
          5: blk = {blk, (kind == DescFeature && $urandom_range(0, 2) == 0) ?
                         8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255))};
          default: blk = {blk, 8'($urandom_range(0, 255))};
        endcase
      end
      // Leave the final descriptor unfinished when the block is to be cut short.
      if (ending == EndCutShort && d == ndesc - 1)
        repeat ($urandom_range(1, len - 1)) void'(blk.pop_back());
    end
    if (ending == EndBadLength) begin
      blk = {blk, 8'($urandom_range(0, 1))};
      repeat ($urandom_range(0, 4)) blk = {blk, 8'($urandom_range(0, 255))};
    end
    if (ending == EndNoise)
      repeat ($urandom_range(1, 16)) blk = {blk, 8'($urandom_range(0, 255))};
    foreach (blk[i]) begin
      t.data  = blk[i];
      t.last  = (i == blk.size() - 1);
      t.typed = 1'b0;
      t.want  = '0;
      byte_stream = {byte_stream, t};
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sink: alternates ready runs and stalls of random length, with long ready stretches now and then.
  logic sink_on = 1'b0;
  int   sink_left = 0;
  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_on = !sink_on;
      if (sink_on)
        sink_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      else
        sink_left = $urandom_range(1, 6);
    end
    sink_left--;
    m_axis_tready_i <= sink_on;
  end

  // Every summary transfer is compared with the oldest expected summary.
  summary_t got_summary, want_summary;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_summary = m_axis_tdata_o;
      if (pending_summaries.size() == 0) begin
        $error("summary transfer with no block pending: 0x%h", got_summary);
        mismatches++;
      end else begin
        want_summary = pending_summaries.pop_front();
        check_field("uac_version", 32'(want_summary.uac_version),
                    32'(got_summary.uac_version));
        check_field("clock_source_id", 32'(want_summary.clock_source_id),
                    32'(got_summary.clock_source_id));
        check_field("clock_source_found", 32'(want_summary.clock_source_found),
                    32'(got_summary.clock_source_found));
        check_field("clock_programmable", 32'(want_summary.clock_programmable),
                    32'(got_summary.clock_programmable));
        check_field("clock_selector_id", 32'(want_summary.clock_selector_id),
                    32'(got_summary.clock_selector_id));
        check_field("clock_selector_found", 32'(want_summary.clock_selector_found),
                    32'(got_summary.clock_selector_found));
        check_field("feature_unit_id", 32'(want_summary.feature_unit_id),
                    32'(got_summary.feature_unit_id));
        check_field("feature_unit_found", 32'(want_summary.feature_unit_found),
                    32'(got_summary.feature_unit_found));
        check_field("volume_host_control", 32'(want_summary.volume_host_control),
                    32'(got_summary.volume_host_control));
        check_field("volume_kind", 32'(want_summary.volume_kind),
                    32'(got_summary.volume_kind));
        check_field("walk_stopped", 32'(want_summary.walk_stopped),
                    32'(got_summary.walk_stopped));
      end
    end
  end

  // Watchdog: too many cycles without a transfer on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    transfer_t cur;
    summary_t  predicted;
    logic      emitted;
    int        gap, burst_left, next_summary;
    next_summary = 0;
    foreach (DirBytes[i]) begin
      cur.data  = DirBytes[i][7:0];
      cur.last  = DirBytes[i][8];
      cur.typed = cur.last;
      cur.want  = '0;
      if (cur.last) begin
        cur.want = DirSummaries[next_summary];
        next_summary++;
      end
      byte_stream = {byte_stream, cur};
    end
    while (byte_stream.size() < DirCount + RandomItems) build_block();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Source: bursts of random length separated by random gaps.
    burst_left = 0;
    while (byte_stream.size() != 0) begin
      cur = byte_stream.pop_front();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) :
                                                   $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= cur.data;
      s_axis_tlast_i  <= cur.last;
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      walk_descriptor_byte(cur.data, cur.last, emitted, predicted);
      if (emitted) begin
        if (cur.typed) pending_summaries = {pending_summaries, cur.want};
        else pending_summaries = {pending_summaries, predicted};
      end
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ucdp_pkg.sv
rtl/ucdp_desc_eval.sv
rtl/uac_control_descriptor_parser_core.sv
verif/testbench.sv
